>>> src/arpc_pkg.sv
// Shared types and constants for the ARP cache with request retry.
`default_nettype none

package arpc_pkg;

  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int AGE_W  = 16;
  localparam int TIME_W = 32;
  localparam int RI_W   = 16;
  localparam int STAT_W = 2;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 3;

  localparam logic [AGE_W-1:0] AGE_RESET = 16'd100;
  localparam logic [RI_W-1:0]  RI_RESET  = 16'd1000;

  localparam logic ACT_RESOLVE = 1'b0;
  localparam logic ACT_LEARN   = 1'b1;

  localparam logic [STAT_W-1:0] STAT_FOUND   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_WAITING = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ISSUED  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_LEARNED = 2'd3;

  localparam logic [1:0] MARK_VALID = 2'b01;
  localparam logic [1:0] MARK_WAIT  = 2'b10;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [AGE_W-1:0]  age;
    logic [TIME_W-1:0] deadline;
    logic [1:0]        mark;
  } arpc_entry_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic decide;
    logic fetch;
    logic apply;
    logic emit;
  } arpc_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } arpc_sts_t;

endpackage

`default_nettype wire

>>> src/arp_cache_with_retry_top.sv
// Top level of the ARP cache with request retry.
//
//  channel | direction | tdata / data                          | tuser
//  in_     | slave     | [31:0] ip, [79:32] mac, [111:80] now  | [0] action
//  out_    | master    | [47:0] mac_result                     | [1:0] status, [2] send_request
//  cfg_    | slave     | [15:0] retry_interval                 | -
//
// After a word is accepted the table is scanned, one table read per cycle over every entry; a
// drain state lets the last read return, then come a decision, a re-read of the chosen entry
// and its update, all through the single read port, before the result is emitted. The next
// word is taken only after that, so one word is in progress at a time.
// Reset clears all entry valid bits at once; no clearing pass is needed.
// A result held by out_tready does not block acceptance on in_; the following word stalls in
// its last cycle until the result register frees.
`default_nettype none

module arp_cache_with_retry_top
  import arpc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // ip_address, mac_address, now
  input  wire logic                  in_tuser,   // action
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // mac_result
  output logic      [OUT_USER_W-1:0] out_tuser,  // status, send_request
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [RI_W-1:0]       cfg_data    // retry_interval
);

  arpc_cmd_t cmd;
  arpc_sts_t sts;

  assign cfg_ready = 1'b1;

  arpc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  arpc_dp #(
    .ENTRIES(ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_user  (in_tuser),
    .in_data  (in_tdata),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_tdata),
    .out_user (out_tuser)
  );

`ifndef ASSERT_OFF
  a_send_iff_issued: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[2] == (out_tuser[1:0] == STAT_ISSUED)))
    else $error("send_request disagrees with status");

  a_mac_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[1:0] != STAT_FOUND)) |-> (out_tdata == '0))
    else $error("mac_result nonzero without a hit");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word taken while one is in progress");
`endif

endmodule

`default_nettype wire

>>> src/arpc_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

>>> src/arpc_ctrl.sv
// Sequencing state machine for the ARP cache: scan, decide, read, update, emit.
`default_nettype none

module arpc_ctrl
  import arpc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire arpc_sts_t sts,
  output arpc_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_APPLY  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_READ;
      end
      S_READ: begin
        cmd.fetch = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.emit = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/arpc_dp.sv
// Datapath for the ARP cache: entry table, scan candidates, update and result register.
`default_nettype none

module arpc_dp
  import arpc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire arpc_cmd_t             cmd,
  output arpc_sts_t                  sts,
  input  wire logic                  in_user,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire logic                  cfg_valid,
  input  wire logic [RI_W-1:0]       cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [OUT_DATA_W-1:0] out_data,
  output logic      [OUT_USER_W-1:0] out_user
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int EW = $bits(arpc_entry_t);

  localparam logic [1:0] K_FOUND = 2'd0;
  localparam logic [1:0] K_CHECK = 2'd1;
  localparam logic [1:0] K_CLAIM = 2'd2;
  localparam logic [1:0] K_LEARN = 2'd3;

  logic                act_r;
  logic [IP_W-1:0]     ip_r;
  logic [MAC_W-1:0]    mac_r;
  logic [TIME_W-1:0]   now_r;
  logic [RI_W-1:0]     ri_r;
  logic [AGE_W-1:0]    age_cnt_r;
  logic [ENTRIES-1:0]  valid_r;

  logic [IW-1:0]       scan_idx_r;
  logic                rd_scan_r;
  logic [IW-1:0]       rd_idx_r;
  logic                rd_ok_r;

  logic                hit_f_r, wt_f_r, any_f_r, emp_f_r;
  logic [IW-1:0]       hit_idx_r, wt_idx_r, any_idx_r, emp_idx_r, min_idx_r;
  logic [AGE_W-1:0]    min_age_r;

  logic [1:0]          kind_r;
  logic [IW-1:0]       slot_r;

  logic [STAT_W-1:0]   res_stat_r;
  logic [MAC_W-1:0]    res_mac_r;
  logic                res_send_r;

  logic                out_valid_r;
  logic [STAT_W-1:0]   out_stat_r;
  logic [MAC_W-1:0]    out_mac_r;
  logic                out_send_r;

  logic [IW-1:0]       raddr;
  logic [EW-1:0]       ram_q;
  arpc_entry_t         ent;
  logic                ent_match;
  logic [IW-1:0]       pick;
  logic [TIME_W-1:0]   next_dl;
  logic [AGE_W-1:0]    age_nxt;
  logic                wr_en;
  arpc_entry_t         wr_ent;
  logic [STAT_W-1:0]   stat_nxt;
  logic [MAC_W-1:0]    rmac_nxt;
  logic                send_nxt;

  assign raddr     = cmd.fetch ? slot_r : scan_idx_r;
  assign ent       = rd_ok_r ? arpc_entry_t'(ram_q) : '0;
  assign ent_match = (ent.ip == ip_r);
  assign pick      = emp_f_r ? emp_idx_r : min_idx_r;
  assign next_dl   = now_r + {{(TIME_W-RI_W){1'b0}}, ri_r};
  assign age_nxt   = age_cnt_r + 16'd1;

  assign sts.scan_last = (scan_idx_r == IW'(ENTRIES - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_mac_r;
  assign out_user  = {out_send_r, out_stat_r};

  arpc_ram #(
    .WIDTH(EW),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (cmd.apply && wr_en),
    .waddr(slot_r),
    .wdata(wr_ent),
    .raddr(raddr),
    .rdata(ram_q)
  );

  always_comb begin
    wr_en    = 1'b0;
    wr_ent   = ent;
    stat_nxt = STAT_FOUND;
    rmac_nxt = '0;
    send_nxt = 1'b0;
    unique case (kind_r)
      K_FOUND: begin
        rmac_nxt = ent.mac;
      end
      K_CHECK: begin
        if (ent.deadline > now_r) begin
          stat_nxt = STAT_WAITING;
        end else begin
          wr_en           = 1'b1;
          wr_ent.deadline = next_dl;
          stat_nxt        = STAT_ISSUED;
          send_nxt        = 1'b1;
        end
      end
      K_CLAIM: begin
        wr_en           = 1'b1;
        wr_ent.ip       = ip_r;
        wr_ent.age      = age_nxt;
        wr_ent.deadline = next_dl;
        wr_ent.mark     = MARK_WAIT;
        stat_nxt        = STAT_ISSUED;
        send_nxt        = 1'b1;
      end
      K_LEARN: begin
        wr_en       = 1'b1;
        wr_ent.ip   = ip_r;
        wr_ent.mac  = mac_r;
        wr_ent.age  = age_nxt;
        wr_ent.mark = MARK_VALID;
        stat_nxt    = STAT_LEARNED;
      end
      default: begin
        stat_nxt = STAT_FOUND;
      end
    endcase
  end

  // Hold the item, scan candidates, the chosen slot and kind, and the result and output registers.
  always_ff @(posedge clk) begin
    rd_idx_r <= raddr;
    rd_ok_r  <= valid_r[raddr];
    if (cmd.start) begin
      act_r      <= in_user;
      ip_r       <= in_data[31:0];
      mac_r      <= in_data[79:32];
      now_r      <= in_data[111:80];
      scan_idx_r <= '0;
    end else if (cmd.scan) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
    if (rd_scan_r) begin
      if (ent_match && ent.mark[0] && !hit_f_r) begin
        hit_idx_r <= rd_idx_r;
      end
      if (ent_match && ent.mark[1] && !wt_f_r) begin
        wt_idx_r <= rd_idx_r;
      end
      if (ent_match && !any_f_r) begin
        any_idx_r <= rd_idx_r;
      end
      if ((ent.ip == '0) && !emp_f_r) begin
        emp_idx_r <= rd_idx_r;
      end
      if ((rd_idx_r == '0) || (ent.age < min_age_r)) begin
        min_idx_r <= rd_idx_r;
        min_age_r <= ent.age;
      end
    end
    if (cmd.decide) begin
      if (act_r == ACT_LEARN) begin
        kind_r <= K_LEARN;
        slot_r <= any_f_r ? any_idx_r : pick;
      end else if (hit_f_r) begin
        kind_r <= K_FOUND;
        slot_r <= hit_idx_r;
      end else if (wt_f_r) begin
        kind_r <= K_CHECK;
        slot_r <= wt_idx_r;
      end else begin
        kind_r <= K_CLAIM;
        slot_r <= pick;
      end
    end
    if (cmd.apply) begin
      res_stat_r <= stat_nxt;
      res_mac_r  <= rmac_nxt;
      res_send_r <= send_nxt;
    end
    if (cmd.emit) begin
      out_stat_r <= res_stat_r;
      out_mac_r  <= res_mac_r;
      out_send_r <= res_send_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ri_r        <= RI_RESET;
      age_cnt_r   <= AGE_RESET;
      valid_r     <= '0;
      rd_scan_r   <= 1'b0;
      hit_f_r     <= 1'b0;
      wt_f_r      <= 1'b0;
      any_f_r     <= 1'b0;
      emp_f_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_scan_r <= cmd.scan;
      if (cfg_valid) begin
        ri_r <= cfg_data;
      end
      if (cmd.start) begin
        hit_f_r <= 1'b0;
        wt_f_r  <= 1'b0;
        any_f_r <= 1'b0;
        emp_f_r <= 1'b0;
      end else if (rd_scan_r) begin
        if (ent_match && ent.mark[0]) begin
          hit_f_r <= 1'b1;
        end
        if (ent_match && ent.mark[1]) begin
          wt_f_r <= 1'b1;
        end
        if (ent_match) begin
          any_f_r <= 1'b1;
        end
        if (ent.ip == '0) begin
          emp_f_r <= 1'b1;
        end
      end
      if (cmd.apply && wr_en) begin
        valid_r[slot_r] <= 1'b1;
      end
      if (cmd.apply && ((kind_r == K_CLAIM) || (kind_r == K_LEARN))) begin
        age_cnt_r <= age_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> test/tb_arp_cache_with_retry_top.sv
// Self-checking testbench for the ARP cache with request retry, with a reference predictor.
`default_nettype none

module tb_arp_cache_with_retry_top
  import arpc_pkg::*;
;

  localparam int ENTRIES     = 16;
  localparam int POOL_N      = 24;
  localparam int DIR_N       = 22;
  localparam int PHASE_N     = 5;
  localparam int PHASE_ITEMS = 140;
  localparam int SETTLE      = 2 * ENTRIES + 16;
  localparam int CYCLE_LIMIT = 500_000;

  typedef struct packed {
    logic              act;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] now;
  } arp_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [MAC_W-1:0]  mac;
    logic              send;
  } arp_reply_t;

  typedef struct packed {
    arp_req_t   req;
    logic       known;
    arp_reply_t reply;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [RI_W-1:0]       cfg_data = '0;

  logic [IP_W-1:0]   tbl_ip [ENTRIES];
  logic [MAC_W-1:0]  tbl_mac [ENTRIES];
  logic [AGE_W-1:0]  tbl_age [ENTRIES];
  logic [TIME_W-1:0] tbl_deadline [ENTRIES];
  logic [1:0]        tbl_mark [ENTRIES];
  logic [AGE_W-1:0]  stamp_ctr;
  logic [RI_W-1:0]   retry_ticks;

  arp_reply_t        pending_replies [$];
  arp_reply_t        want;
  dir_row_t          dir_tab [DIR_N];
  logic [IP_W-1:0]   ip_pool [POOL_N];
  logic [RI_W-1:0]   retry_set [PHASE_N];
  logic [TIME_W-1:0] clock_now;
  int                fail_count = 0;
  int                cycles = 0;
  int                burst_left = 0;
  int                rdy_run = 0;
  int                rdy_hold = 0;

  arp_cache_with_retry_top #(.ENTRIES(ENTRIES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // ip_address, mac_address, now
    .in_tuser  (in_tuser),   // action
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // mac_result
    .out_tuser (out_tuser),  // status, send_request
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)    // retry_interval
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rdy_hold > 0) begin
      out_tready <= 1'b0;
      rdy_hold <= rdy_hold - 1;
    end else if (rdy_run > 0) begin
      out_tready <= 1'b1;
      rdy_run <= rdy_run - 1;
    end else begin
      out_tready <= 1'b0;
      rdy_run <= $urandom_range(0, 40);
      rdy_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word status %0d mac %h send %b", $time,
                 out_tuser[1:0], out_tdata, out_tuser[2]);
      end else begin
        want = pending_replies.pop_front();
        if (out_tuser[1:0] !== want.status) begin
          fail_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser[1:0]);
        end
        if (out_tdata !== want.mac) begin
          fail_count++;
          $display("%0t: mac_result expected %h actual %h", $time, want.mac, out_tdata);
        end
        if (out_tuser[2] !== want.send) begin
          fail_count++;
          $display("%0t: send_request expected %b actual %b", $time, want.send, out_tuser[2]);
        end
      end
    end
  end

  function automatic int victim_slot();
    int best;
    best = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_ip[i] == '0) return i;
    end
    for (int i = 1; i < ENTRIES; i++) begin
      if (tbl_age[i] < tbl_age[best]) best = i;
    end
    return best;
  endfunction

  function automatic arp_reply_t cache_update(input arp_req_t r);
    arp_reply_t        rep;
    int                slot;
    logic [TIME_W-1:0] next_dl;
    rep = '0;
    slot = -1;
    next_dl = r.now + TIME_W'(retry_ticks);
    if (r.act == ACT_LEARN) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && tbl_ip[i] == r.ip) slot = i;
      end
      if (slot < 0) slot = victim_slot();
      tbl_ip[slot] = r.ip;
      tbl_mac[slot] = r.mac;
      stamp_ctr = stamp_ctr + 1'b1;
      tbl_age[slot] = stamp_ctr;
      tbl_mark[slot] = MARK_VALID;
      rep.status = STAT_LEARNED;
      return rep;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_ip[i] == r.ip && (tbl_mark[i] & MARK_VALID) != 2'b00) begin
        rep.status = STAT_FOUND;
        rep.mac = tbl_mac[i];
        return rep;
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_ip[i] == r.ip && (tbl_mark[i] & MARK_WAIT) != 2'b00) begin
        if (tbl_deadline[i] > r.now) begin
          rep.status = STAT_WAITING;
        end else begin
          tbl_deadline[i] = next_dl;
          rep.status = STAT_ISSUED;
          rep.send = 1'b1;
        end
        return rep;
      end
    end
    slot = victim_slot();
    tbl_ip[slot] = r.ip;
    tbl_mark[slot] = MARK_WAIT;
    tbl_deadline[slot] = next_dl;
    stamp_ctr = stamp_ctr + 1'b1;
    tbl_age[slot] = stamp_ctr;
    rep.status = STAT_ISSUED;
    rep.send = 1'b1;
    return rep;
  endfunction

  function automatic arp_req_t next_request();
    arp_req_t r;
    int       pick;
    int       s;
    pick = $urandom_range(0, 99);
    r.act = ACT_RESOLVE;
    r.ip = ip_pool[$urandom_range(0, POOL_N - 1)];
    r.mac = MAC_W'({$urandom(), $urandom()});
    clock_now = clock_now + TIME_W'($urandom_range(0, 400));
    if (pick < 5) clock_now = clock_now + TIME_W'($urandom_range(0, 70000));
    r.now = clock_now;
    if (pick >= 60 && pick < 80) begin
      r.act = ACT_LEARN;
    end else if (pick >= 80 && pick < 88) begin
      s = $urandom_range(0, ENTRIES - 1);
      r.ip = tbl_ip[s];
      r.now = tbl_deadline[s] - TIME_W'($urandom_range(0, 1));
    end else if (pick >= 88 && pick < 90) begin
      r.ip = '0;
    end else if (pick >= 90) begin
      r.act = 1'($urandom_range(0, 1));
      r.ip = $urandom();
      r.now = $urandom();
    end
    return r;
  endfunction

  task automatic send_word(input arp_req_t r, input logic known, input arp_reply_t typed);
    arp_reply_t rep;
    in_tvalid <= 1'b1;
    in_tuser <= r.act;
    in_tdata <= {r.now, r.mac, r.ip};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rep = cache_update(r);
    pending_replies.push_back(known ? typed : rep);
  endtask

  task automatic hold_off(input int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 30));
    end
    burst_left--;
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_retry(input logic [RI_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    retry_ticks = v;
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_ip[i] = '0;
      tbl_mac[i] = '0;
      tbl_age[i] = '0;
      tbl_deadline[i] = '0;
      tbl_mark[i] = '0;
    end
    stamp_ctr = AGE_RESET;
    retry_ticks = RI_RESET;
    for (int i = 0; i < POOL_N; i++) ip_pool[i] = $urandom();
    retry_set[0] = 16'd0;
    retry_set[1] = 16'hFFFF;
    retry_set[2] = 16'd1;
    retry_set[3] = RI_W'($urandom());
    retry_set[4] = RI_W'($urandom_range(100, 3000));

    dir_tab[0]  = {ACT_RESOLVE, 32'h0A00_0001, 48'h0, 32'd0,
                   1'b1, STAT_ISSUED, 48'h0, 1'b1};
    dir_tab[1]  = {ACT_RESOLVE, 32'h0A00_0001, 48'h0, 32'd999,
                   1'b1, STAT_WAITING, 48'h0, 1'b0};
    dir_tab[2]  = {ACT_RESOLVE, 32'h0A00_0001, 48'h0, 32'd1000,
                   1'b1, STAT_ISSUED, 48'h0, 1'b1};
    dir_tab[3]  = {ACT_LEARN, 32'h0A00_0001, 48'hFFFF_FFFF_FFFF, 32'd1500,
                   1'b1, STAT_LEARNED, 48'h0, 1'b0};
    dir_tab[4]  = {ACT_RESOLVE, 32'h0A00_0001, 48'h0, 32'd0,
                   1'b1, STAT_FOUND, 48'hFFFF_FFFF_FFFF, 1'b0};
    dir_tab[5]  = {ACT_RESOLVE, 32'hFFFF_FFFF, 48'h0, 32'hFFFF_FFFF,
                   1'b1, STAT_ISSUED, 48'h0, 1'b1};
    dir_tab[6]  = {ACT_RESOLVE, 32'hFFFF_FFFF, 48'h0, 32'hFFFF_FFFF,
                   1'b1, STAT_ISSUED, 48'h0, 1'b1};
    dir_tab[7]  = {ACT_RESOLVE, 32'hFFFF_FFFF, 48'h0, 32'd0,
                   1'b1, STAT_WAITING, 48'h0, 1'b0};
    dir_tab[8]  = {ACT_RESOLVE, 32'h0, 48'h0, 32'd5,
                   1'b1, STAT_ISSUED, 48'h0, 1'b1};
    dir_tab[9]  = {ACT_RESOLVE, 32'h0, 48'h0, 32'd6,
                   1'b1, STAT_WAITING, 48'h0, 1'b0};
    dir_tab[10] = {ACT_LEARN, 32'h0, 48'h1234_5678_9ABC, 32'd7,
                   1'b1, STAT_LEARNED, 48'h0, 1'b0};
    dir_tab[11] = {ACT_RESOLVE, 32'h0, 48'h0, 32'd8,
                   1'b1, STAT_FOUND, 48'h1234_5678_9ABC, 1'b0};
    dir_tab[12] = {ACT_LEARN, 32'hC0A8_0001, 48'h0, 32'd9,
                   1'b1, STAT_LEARNED, 48'h0, 1'b0};
    dir_tab[13] = {ACT_RESOLVE, 32'hC0A8_0001, 48'hAAAA_AAAA_AAAA, 32'd10,
                   1'b1, STAT_FOUND, 48'h0, 1'b0};
    dir_tab[14] = {ACT_RESOLVE, 32'h0, 48'h0, 32'd11,
                   1'b0, STAT_FOUND, 48'h0, 1'b0};
    dir_tab[15] = {ACT_LEARN, 32'h5555_5555, 48'h5555_5555_5555, 32'hAAAA_AAAA,
                   1'b1, STAT_LEARNED, 48'h0, 1'b0};
    dir_tab[16] = {ACT_LEARN, 32'h0A00_0001, 48'h0000_0000_0001, 32'd20,
                   1'b1, STAT_LEARNED, 48'h0, 1'b0};
    dir_tab[17] = {ACT_RESOLVE, 32'h0A00_0001, 48'h0, 32'd21,
                   1'b1, STAT_FOUND, 48'h0000_0000_0001, 1'b0};
    dir_tab[18] = {ACT_LEARN, 32'h0, 48'h0000_00AB_CDEF, 32'd12,
                   1'b1, STAT_LEARNED, 48'h0, 1'b0};
    dir_tab[19] = {ACT_RESOLVE, 32'h0, 48'h0, 32'd13,
                   1'b1, STAT_FOUND, 48'h0000_00AB_CDEF, 1'b0};
    dir_tab[20] = {ACT_RESOLVE, 32'h0B00_0001, 48'h0, 32'd100,
                   1'b0, STAT_FOUND, 48'h0, 1'b0};
    dir_tab[21] = {ACT_RESOLVE, 32'h0B00_0001, 48'h0, 32'd1099,
                   1'b0, STAT_FOUND, 48'h0, 1'b0};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      pace();
      send_word(dir_tab[i].req, dir_tab[i].known, dir_tab[i].reply);
    end
    drain_replies();

    for (int ph = 0; ph < PHASE_N; ph++) begin
      write_retry(retry_set[ph]);
      clock_now = (ph == 2) ? 32'hFFFF_FC00 : TIME_W'($urandom_range(0, 1 << 20));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pace();
        if ($urandom_range(0, 59) == 0) drain_replies();
        send_word(next_request(), 1'b0, '0);
      end
      drain_replies();
    end

    if (pending_replies.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> arp_cache_with_retry_top.f
src/arpc_pkg.sv
src/arpc_ram.sv
src/arpc_ctrl.sv
src/arpc_dp.sv
src/arp_cache_with_retry_top.sv
test/tb_arp_cache_with_retry_top.sv
